// File: hdl/sexpr_pkg.sv
// Types, character codes and lexer state codes for the s-expression tokenizer.
`timescale 1ns / 1ps

package sexpr_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_text;
	} byte_req_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  char_out;
		logic [1:0]  token_class;
		logic [15:0] line_number;
		logic        last;
	} tok_req_t;

	localparam logic [2:0] EV_OPEN      = 3'd0;
	localparam logic [2:0] EV_CLOSE     = 3'd1;
	localparam logic [2:0] EV_CHAR      = 3'd2;
	localparam logic [2:0] EV_TOK_END   = 3'd3;
	localparam logic [2:0] EV_BRKT_ERR  = 3'd4;
	localparam logic [2:0] EV_EOT       = 3'd5;

	localparam logic [1:0] CLS_STRING = 2'd0;
	localparam logic [1:0] CLS_IDENT  = 2'd1;
	localparam logic [1:0] CLS_INT    = 2'd2;
	localparam logic [1:0] CLS_FLOAT  = 2'd3;

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_DQ      = 3'd2;
	localparam logic [2:0] MODE_DQ_ESC  = 3'd3;
	localparam logic [2:0] MODE_SQ      = 3'd4;
	localparam logic [2:0] MODE_WORD    = 3'd5;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_LOW_N  = 8'h6e;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	localparam logic [15:0] LINE_MAX = 16'hffff;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [7:0] map_escape(input logic [7:0] c);
		case (c)
			CH_LOW_T: return CH_TAB;
			CH_LOW_R: return CH_CR;
			CH_LOW_N: return CH_LF;
			default:  return c;
		endcase
	endfunction

	// flags: [0] leading digit, [1] leading minus, [2] second byte digit, [3] dot seen
	function automatic logic [1:0] word_class(input logic [3:0] f);
		logic num;
		num = f[0] || (f[1] && f[2]);
		if (!num)
			return CLS_IDENT;
		return f[3] ? CLS_FLOAT : CLS_INT;
	endfunction

endpackage

// File: hdl/sexpr_tokenizer.sv
// Top level of the byte-serial s-expression tokenizer.
//
// Usage: text enters one byte per request on the byte channel (char_in plus an
// end_of_text mark on the final byte). Token events leave on the tok channel,
// one event per request, each carrying the line count after the byte's own LF
// and a last mark on the final event that the byte caused.
// The first event of a byte is offered in the cycle after the byte is
// taken. A byte causes zero to three events.
// Throughput: one byte per cycle while each byte causes at most one event and
// the receiver takes every event; a byte with several events holds the tok
// channel until each one is taken, and the next byte is taken in the cycle its
// last event is taken. A three-entry result register holds the events of one
// byte. Bytes that cause no event (whitespace, comments, opening quotes) are
// taken and produce nothing on the tok channel.
// Stall: while the receiver holds tok_ready low, the pending events hold;
// byte_ready stays low while more than one event waits, or while one waits
// and is not taken.
// Reset: arst_n clears the lexer to idle, the line count to zero and the
// result register to empty. The end_of_text byte also returns the lexer to
// that state after its events are formed.
`timescale 1ns / 1ps

module sexpr_tokenizer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  sexpr_pkg::byte_req_t  byte_req,
	output logic                  tok_valid,
	input  logic                  tok_ready,
	output sexpr_pkg::tok_req_t   tok_req
);
	import sexpr_pkg::*;

	logic [2:0]  mode_q;
	logic [15:0] line_q;
	logic [3:0]  flags_q;
	logic [1:0]  pos_q;
	logic [1:0]  cnt_q;
	tok_req_t    res_q [3];

	logic        accept;
	logic        pop;
	logic [2:0]  mode;
	logic [2:0]  mode_nx;
	logic [15:0] line_nx;
	logic [3:0]  flags_nx;
	logic [1:0]  pos_nx;
	logic [3:0]  wf_base;
	logic [1:0]  wp_base;
	logic        wbyte;
	logic        wstart;
	logic [7:0]  c;
	logic        eot;
	logic        ev_v   [4];
	logic [2:0]  ev_code[4];
	logic [7:0]  ev_ch  [4];
	logic [1:0]  ev_cls [4];
	tok_req_t    slot   [3];
	logic [1:0]  n;

	assign pop        = tok_valid && tok_ready;
	assign byte_ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && tok_ready);
	assign accept     = byte_valid && byte_ready;
	assign tok_valid  = (cnt_q != 2'd0);
	assign tok_req    = res_q[0];

	assign c   = byte_req.char_in;
	assign eot = byte_req.end_of_text;

	always_comb begin
		mode    = (mode_q > MODE_WORD) ? MODE_IDLE : mode_q;
		mode_nx = mode;
		line_nx = ((c == CH_LF) && (line_q != LINE_MAX)) ? line_q + 16'd1 : line_q;
		wbyte   = 1'b0;
		wstart  = 1'b0;
		for (int k = 0; k < 4; k++) begin
			ev_v[k]    = 1'b0;
			ev_code[k] = EV_OPEN;
			ev_ch[k]   = 8'd0;
			ev_cls[k]  = CLS_STRING;
		end

		unique case (mode)
			MODE_IDLE: begin
				if (is_space(c)) begin
				end else if (c == CH_SEMI) begin
					mode_nx = MODE_COMMENT;
				end else if (c == CH_LPAREN) begin
					ev_v[0]    = 1'b1;
					ev_code[0] = EV_OPEN;
				end else if (c == CH_RPAREN) begin
					ev_v[0]    = 1'b1;
					ev_code[0] = EV_CLOSE;
				end else if (c == CH_DQUOTE) begin
					mode_nx = MODE_DQ;
				end else if (c == CH_SQUOTE) begin
					mode_nx = MODE_SQ;
				end else begin
					mode_nx    = MODE_WORD;
					wbyte      = 1'b1;
					wstart     = 1'b1;
					ev_v[0]    = 1'b1;
					ev_code[0] = EV_CHAR;
					ev_ch[0]   = c;
				end
			end
			MODE_COMMENT: begin
				if (c == CH_LF)
					mode_nx = MODE_IDLE;
			end
			MODE_DQ: begin
				if (c == CH_DQUOTE) begin
					ev_v[0]    = 1'b1;
					ev_code[0] = EV_TOK_END;
					mode_nx    = MODE_IDLE;
				end else if (c == CH_BSLASH) begin
					mode_nx = MODE_DQ_ESC;
				end else begin
					ev_v[0]    = 1'b1;
					ev_code[0] = EV_CHAR;
					ev_ch[0]   = c;
				end
			end
			MODE_DQ_ESC: begin
				ev_v[0]    = 1'b1;
				ev_code[0] = EV_CHAR;
				ev_ch[0]   = map_escape(c);
				mode_nx    = MODE_DQ;
			end
			MODE_SQ: begin
				ev_v[0] = 1'b1;
				if (c == CH_SQUOTE) begin
					ev_code[0] = EV_TOK_END;
					mode_nx    = MODE_IDLE;
				end else begin
					ev_code[0] = EV_CHAR;
					ev_ch[0]   = c;
				end
			end
			default: begin
				ev_v[0] = 1'b1;
				if (is_space(c)) begin
					ev_code[0] = EV_TOK_END;
					ev_cls[0]  = word_class(flags_q);
					mode_nx    = MODE_IDLE;
				end else if (c == CH_RPAREN) begin
					ev_code[0] = EV_TOK_END;
					ev_cls[0]  = word_class(flags_q);
					ev_v[1]    = 1'b1;
					ev_code[1] = EV_CLOSE;
					mode_nx    = MODE_IDLE;
				end else if (c == CH_LPAREN) begin
					ev_code[0] = EV_BRKT_ERR;
					mode_nx    = MODE_IDLE;
				end else begin
					wbyte      = 1'b1;
					ev_code[0] = EV_CHAR;
					ev_ch[0]   = c;
				end
			end
		endcase

		wf_base  = wstart ? 4'd0 : flags_q;
		wp_base  = wstart ? 2'd0 : pos_q;
		flags_nx = wf_base;
		pos_nx   = wp_base;
		if (wbyte) begin
			if (wp_base == 2'd0) begin
				if (is_digit(c))
					flags_nx[0] = 1'b1;
				if (c == CH_MINUS)
					flags_nx[1] = 1'b1;
			end else if (wp_base == 2'd1) begin
				if (is_digit(c))
					flags_nx[2] = 1'b1;
			end
			if (c == CH_DOT)
				flags_nx[3] = 1'b1;
			if (wp_base < 2'd2)
				pos_nx = wp_base + 2'd1;
		end

		// close an open token, then mark end of text
		if (eot) begin
			if (mode_nx == MODE_WORD) begin
				ev_v[2]    = 1'b1;
				ev_code[2] = EV_TOK_END;
				ev_cls[2]  = word_class(flags_nx);
			end else if ((mode_nx == MODE_DQ) || (mode_nx == MODE_DQ_ESC)
					|| (mode_nx == MODE_SQ)) begin
				ev_v[2]    = 1'b1;
				ev_code[2] = EV_TOK_END;
			end
			ev_v[3]    = 1'b1;
			ev_code[3] = EV_EOT;
		end

		n = 2'd0;
		for (int k = 0; k < 3; k++) begin
			slot[k].event_res   = EV_OPEN;
			slot[k].char_out    = 8'd0;
			slot[k].token_class = CLS_STRING;
			slot[k].line_number = line_nx;
			slot[k].last        = 1'b0;
		end
		for (int k = 0; k < 4; k++) begin
			if (ev_v[k] && (n != 2'd3)) begin
				slot[n].event_res   = ev_code[k];
				slot[n].char_out    = ev_ch[k];
				slot[n].token_class = ev_cls[k];
				n                   = n + 2'd1;
			end
		end
		if (n != 2'd0)
			slot[n - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			line_q  <= 16'd0;
			flags_q <= 4'd0;
			pos_q   <= 2'd0;
			cnt_q   <= 2'd0;
		end else begin
			if (accept) begin
				cnt_q <= n;
				if (eot) begin
					mode_q  <= MODE_IDLE;
					line_q  <= 16'd0;
					flags_q <= 4'd0;
					pos_q   <= 2'd0;
				end else begin
					mode_q  <= mode_nx;
					line_q  <= line_nx;
					flags_q <= flags_nx;
					pos_q   <= pos_nx;
				end
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// load all events of a byte, advance the queue on each request taken
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q[0] <= slot[0];
			res_q[1] <= slot[1];
			res_q[2] <= slot[2];
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	a_eot_gives_event: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && eot) |=> tok_valid)
		else $error("end of text byte produced no event");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !tok_req.last) |=> tok_valid)
		else $error("event without last mark was not followed by another");

	a_eot_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && eot) |=> ((mode_q == MODE_IDLE) && (line_q == 16'd0)))
		else $error("end of text did not return lexer to idle");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (tok_req.event_res <= EV_EOT))
		else $error("event code out of range");

	a_eot_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && (tok_req.event_res == EV_EOT)) |-> tok_req.last)
		else $error("end of text event not marked last");

endmodule
